/* sv/shist_pkg.sv */
// Shared constants, codes and types of the segmented histogram accumulator.
`default_nettype none

package shist_pkg;

    localparam int SEGMENTS = 64;
    localparam int BINS     = 4096;

    localparam int SEG_AW = $clog2(SEGMENTS);
    localparam int SEG_CW = $clog2(SEGMENTS + 1);
    localparam int BIN_AW = $clog2(BINS);
    localparam int BIN_CW = $clog2(BINS + 1);

    localparam int CMD_W     = 2;
    localparam int SEGMENT_W = 6;
    localparam int LOWEST_W  = 24;
    localparam int COUNT_W   = 13;
    localparam int DIST_W    = 32;
    localparam int ADDR_W    = 12;
    localparam int RECIP_W   = 32;
    localparam int CNT_W     = 32;
    localparam int STATUS_W  = 2;

    localparam logic [RECIP_W-1:0] RECIP_RESET = 32'h0001_0000;
    // One half in Q32.32
    localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CTR_IDLE,
        CTR_INC,
        CTR_READ,
        CTR_READ_CLR
    } ctr_op_t;

    typedef struct packed {
        ctr_op_t           op;
        logic [BIN_AW-1:0] addr;
    } ctr_req_t;

    typedef struct packed {
        logic signed [LOWEST_W-1:0] lowest;
        logic [BIN_CW-1:0]          count;
        logic [BIN_CW-1:0]          base;
    } seg_entry_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RND,
        S_CHK,
        S_RDAT,
        S_DONE
    } fsm_t;

endpackage

`default_nettype wire

/* sv/shist_ifs.sv */
// Valid/ready channel interfaces for command items and result items.
`default_nettype none

interface shist_item_if;
    import shist_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [SEGMENT_W-1:0]       segment;
    logic signed [LOWEST_W-1:0] lowest_bin;
    logic [COUNT_W-1:0]         bin_count;
    logic signed [DIST_W-1:0]   distance;
    logic [ADDR_W-1:0]          address;
    logic                       clear_after_read;

    modport source (
        output valid, cmd, segment, lowest_bin, bin_count, distance, address,
               clear_after_read,
        input  ready
    );

    modport sink (
        input  valid, cmd, segment, lowest_bin, bin_count, distance, address,
               clear_after_read,
        output ready
    );
endinterface

interface shist_result_if;
    import shist_pkg::*;

    logic                valid;
    logic                ready;
    logic [CNT_W-1:0]    count;
    logic [STATUS_W-1:0] status;

    modport source (
        output valid, count, status,
        input  ready
    );

    modport sink (
        input  valid, count, status,
        output ready
    );
endinterface

`default_nettype wire

/* sv/shist_ctr_bank.sv */
// Counter store: synchronous RAM with saturating increment, read-clear and a clearing pass.
`default_nettype none

module shist_ctr_bank (
    input  logic                    clk,
    input  logic                    rst_n,
    input  shist_pkg::ctr_req_t     req,
    output logic [shist_pkg::CNT_W-1:0] rdata,
    output logic                    ready
);
    import shist_pkg::*;

    logic [CNT_W-1:0]  mem [BINS];
    logic [CNT_W-1:0]  rdata_reg;
    ctr_op_t           op_reg;
    logic [BIN_AW-1:0] addr_reg;
    logic              clearing_reg, clearing_next;
    logic [BIN_AW-1:0] clr_idx_reg, clr_idx_next;

    logic              wr_en;
    logic [BIN_AW-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == BIN_AW'(BINS - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // Second half of a request: write back in the cycle after the read
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        if (clearing_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
        end
        else
        begin
            case (op_reg)
                CTR_INC:
                begin
                    wr_en   = 1'b1;
                    wr_data = (rdata_reg == '1) ? rdata_reg : rdata_reg + 1'b1;
                end
                CTR_READ_CLR:
                begin
                    wr_en = 1'b1;
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
            op_reg       <= CTR_IDLE;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
            op_reg       <= req.op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.op != CTR_IDLE)
        begin
            addr_reg  <= req.addr;
            rdata_reg <= mem[req.addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rdata = rdata_reg;
    assign ready = !clearing_reg;

endmodule

`default_nettype wire

/* sv/segmented_histogram_accumulator_top.sv */
// Top level of the segmented histogram accumulator.
`default_nettype none

// Counts samples into a 4096-entry store of 32-bit saturating counters carved into up to
// 64 segments. An append passes through S_DONE on its way to the result register, a read
// through S_RDAT and S_DONE, and a sample through S_RND, S_CHK and S_DONE (segment table
// read with the Q16.16 multiply on acceptance, then rounding, then bounds check and counter
// fetch, with the write-back in S_DONE); a sample to an unloaded segment finishes like an
// append. The block takes the next item once the current one has reached the result
// register, so a waiting result only holds the block when the next item is done.
// After reset the counter RAM is cleared one entry per cycle, with item.ready low; the bin
// width register can be written at any time while idle.
module segmented_histogram_accumulator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [shist_pkg::RECIP_W-1:0] cfg_wr_data,
    shist_item_if.sink                    item,
    shist_result_if.source                result
);
    import shist_pkg::*;

    localparam int SUM_W = ((BIN_CW > COUNT_W) ? BIN_CW : COUNT_W) + 1;
    localparam int REL_W = 34;

    fsm_t                 state_reg, state_next;
    logic [RECIP_W-1:0]   recip_reg;
    logic [SEG_CW-1:0]    loaded_reg;
    logic [BIN_CW-1:0]    allotted_reg;

    seg_entry_t           seg_mem [SEGMENTS];
    seg_entry_t           seg_rd_reg;
    seg_entry_t           seg_wr;

    logic signed [63:0]   prod_reg;
    logic signed [63:0]   prod_next;
    logic signed [32:0]   bin_reg;
    logic [CNT_W-1:0]     res_count_reg;
    status_t              res_status_reg;

    logic                 out_valid_reg;
    logic [CNT_W-1:0]     out_count_reg;
    status_t              out_status_reg;

    ctr_req_t             ctr_req;
    logic [CNT_W-1:0]     ctr_rdata;
    logic                 ctr_ready;

    logic                 accept;
    cmd_t                 cmd;
    logic                 seg_full;
    logic                 store_full;
    logic                 append_ok;
    logic                 seg_unloaded;
    logic                 addr_ok;
    logic signed [63:0]   rnd_sum;
    logic                 rnd_adj;
    logic signed [REL_W-1:0] chk_rel;
    logic                 chk_in;
    logic [BIN_CW:0]      chk_sum;
    logic                 chk_ok;
    logic                 done_load;

    shist_ctr_bank u_ctr_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ctr_req),
        .rdata (ctr_rdata),
        .ready (ctr_ready)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign accept     = item.valid && item.ready;
    assign cmd        = cmd_t'(item.cmd);

    assign seg_full   = int'(loaded_reg) >= SEGMENTS;
    assign store_full = (SUM_W'(allotted_reg) + SUM_W'(item.bin_count)) > SUM_W'(BINS);
    assign append_ok  = !seg_full && !store_full;
    assign seg_unloaded = int'(item.segment) >= int'(loaded_reg);
    assign addr_ok    = int'(item.address) < BINS;

    assign seg_wr.lowest = item.lowest_bin;
    assign seg_wr.count  = BIN_CW'(item.bin_count);
    assign seg_wr.base   = allotted_reg;

    assign prod_next = item.distance * $signed({1'b0, recip_reg});

    // Round half up, then truncate toward zero: floor plus one for a negative fraction
    assign rnd_sum = prod_reg + $signed(HALF_Q32);
    assign rnd_adj = rnd_sum[63] && (rnd_sum[31:0] != '0);

    assign chk_rel = {bin_reg[32], bin_reg}
                   - {{(REL_W - LOWEST_W){seg_rd_reg.lowest[LOWEST_W-1]}}, seg_rd_reg.lowest};
    assign chk_in  = !chk_rel[REL_W-1] && (chk_rel[REL_W-2:0] < (REL_W-1)'(seg_rd_reg.count));
    assign chk_sum = (BIN_CW + 1)'(seg_rd_reg.base) + (BIN_CW + 1)'(chk_rel[BIN_CW-1:0]);
    assign chk_ok  = chk_in && (chk_sum < (BIN_CW + 1)'(BINS));

    assign done_load = (state_reg == S_DONE) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (ctr_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        CMD_SAMPLE: state_next = seg_unloaded ? S_DONE : S_RND;
                        CMD_READ:   state_next = addr_ok ? S_RDAT : S_DONE;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_RND:   state_next = S_CHK;
            S_CHK:   state_next = S_DONE;
            S_RDAT:  state_next = S_DONE;
            S_DONE:
            begin
                if (done_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_comb
    begin
        ctr_req.op   = CTR_IDLE;
        ctr_req.addr = BIN_AW'(item.address);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == CMD_READ) && addr_ok)
                begin
                    ctr_req.op = item.clear_after_read ? CTR_READ_CLR : CTR_READ;
                end
            end
            S_CHK:
            begin
                ctr_req.addr = chk_sum[BIN_AW-1:0];
                if (chk_ok)
                begin
                    ctr_req.op = CTR_INC;
                end
            end
            default:
            begin
                ctr_req.op = CTR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            recip_reg     <= RECIP_RESET;
            loaded_reg    <= '0;
            allotted_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                recip_reg <= cfg_wr_data;
            end
            if (accept && (cmd == CMD_APPEND) && append_ok)
            begin
                loaded_reg   <= loaded_reg + 1'b1;
                allotted_reg <= allotted_reg + BIN_CW'(item.bin_count);
            end
            if (done_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_count_reg <= '0;
            prod_reg      <= prod_next;
            case (cmd)
                CMD_APPEND: res_status_reg <= append_ok ? STAT_OK : STAT_FULL;
                CMD_SAMPLE: res_status_reg <= seg_unloaded ? STAT_FULL : STAT_OK;
                CMD_READ:   res_status_reg <= addr_ok ? STAT_OK : STAT_RANGE;
                default:    res_status_reg <= STAT_OK;
            endcase
            if ((cmd == CMD_APPEND) && append_ok)
            begin
                seg_mem[loaded_reg[SEG_AW-1:0]] <= seg_wr;
            end
            if (cmd == CMD_SAMPLE)
            begin
                seg_rd_reg <= seg_mem[SEG_AW'(item.segment)];
            end
        end
        if (state_reg == S_RND)
        begin
            bin_reg <= {rnd_sum[63], rnd_sum[63:32]} + 33'(rnd_adj);
        end
        if ((state_reg == S_CHK) && !chk_ok)
        begin
            res_status_reg <= STAT_RANGE;
        end
        if (state_reg == S_RDAT)
        begin
            res_count_reg <= ctr_rdata;
        end
        if (done_load)
        begin
            out_count_reg  <= res_count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.count  = out_count_reg;
    assign result.status = out_status_reg;

endmodule

`default_nettype wire

/* sv/shist_checker.sv */
// Port-level checks of the segmented histogram accumulator, bound to its top level.
`default_nettype none

module shist_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [shist_pkg::CNT_W-1:0]    result_count,
    input logic [shist_pkg::STATUS_W-1:0] result_status
);
    import shist_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic       item_beat, result_beat;

    assign item_beat   = item_valid && item_ready;
    assign result_beat = result_valid && result_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (item_beat && !result_beat)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!item_beat && result_beat)
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result beat holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_count) && $stable(result_status))
        else $error("result beat changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_status != 2'd3)
        else $error("result status carries an unused code");

    // Every result beat belongs to an accepted item
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 2'd0)
        else $error("result beat without an accepted item");

    // At most one item in work and one result waiting
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        item_beat |-> pend_reg != 2'd2)
        else $error("item beat taken while a result waits behind a finished item");

endmodule

bind segmented_histogram_accumulator_top shist_checker u_shist_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .result_count  (result.count),
    .result_status (result.status)
);

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the segmented histogram accumulator top level.
`timescale 1ns / 1ps

module testbench;
    import shist_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned      CYCLE_LIMIT = 300000;

    typedef struct {
        logic [CMD_W-1:0]           cmd;
        logic [SEGMENT_W-1:0]       segment;
        logic signed [LOWEST_W-1:0] lowest_bin;
        logic [COUNT_W-1:0]         bin_count;
        logic signed [DIST_W-1:0]   distance;
        logic [ADDR_W-1:0]          address;
        logic                       clear_after_read;
    } command_t;

    typedef struct {
        logic [CNT_W-1:0] count;
        status_t          status;
    } readout_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic [RECIP_W-1:0] cfg_wr_data;

    shist_item_if   item_ch ();
    shist_result_if result_ch ();

    segmented_histogram_accumulator_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch.sink),
        .result      (result_ch.source)
    );

    // Histogram state as the block should hold it
    logic [CNT_W-1:0]   counters [BINS];
    longint             seg_lowest [SEGMENTS];
    int                 seg_count [SEGMENTS];
    int                 seg_base [SEGMENTS];
    int                 segs_loaded;
    int                 bins_used;
    logic [RECIP_W-1:0] recip_now;

    // Segment layout as the stimulus plans it, ahead of acceptance
    longint             plan_lowest [SEGMENTS];
    int                 plan_count [SEGMENTS];
    int                 plan_loaded;
    int                 plan_allotted;
    logic [RECIP_W-1:0] plan_recip;

    command_t    pending_commands [$];
    readout_t    expected_results [$];
    command_t    on_wire;
    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("segmented_histogram_accumulator_top regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic predict_readout(input command_t c);
        readout_t r;
        longint   prod;
        longint   sum;
        longint   bin;
        longint   rel;
        longint   slot;
        int       seg;
        r.count  = '0;
        r.status = STAT_OK;
        seg = int'(c.segment);
        case (c.cmd)
            CMD_APPEND:
            begin
                if (segs_loaded >= SEGMENTS || bins_used + int'(c.bin_count) > BINS)
                    r.status = STAT_FULL;
                else
                begin
                    seg_lowest[segs_loaded] = c.lowest_bin;
                    seg_count[segs_loaded]  = int'(c.bin_count);
                    seg_base[segs_loaded]   = bins_used;
                    bins_used += int'(c.bin_count);
                    segs_loaded++;
                end
            end
            CMD_SAMPLE:
            begin
                if (seg >= segs_loaded)
                    r.status = STAT_FULL;
                else
                begin
                    // Q32.32 product plus one half, truncated toward zero
                    prod = longint'(c.distance) * longint'({32'b0, recip_now});
                    sum  = prod + (longint'(1) <<< 31);
                    if (sum >= 0)
                        bin = sum >>> 32;
                    else
                        bin = -((-sum) >>> 32);
                    rel = bin - seg_lowest[seg];
                    if (rel < 0 || rel >= seg_count[seg])
                        r.status = STAT_RANGE;
                    else
                    begin
                        slot = seg_base[seg] + rel;
                        if (slot >= BINS)
                            r.status = STAT_RANGE;
                        else if (counters[slot] != '1)
                            counters[slot] = counters[slot] + 1;
                    end
                end
            end
            CMD_READ:
            begin
                if (int'(c.address) >= BINS)
                    r.status = STAT_RANGE;
                else
                begin
                    r.count = counters[c.address];
                    if (c.clear_after_read)
                        counters[c.address] = '0;
                end
            end
            default: ;
        endcase
        expected_results.push_back(r);
    endtask

    // Driver: hold a beat until accepted, then maybe idle
    always @(posedge clk or negedge rst_n)
    begin
        command_t next_cmd;
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
                predict_readout(on_wire);
            if (!item_ch.valid || item_ch.ready)
            begin
                if (pending_commands.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_cmd = pending_commands.pop_front();
                    on_wire = next_cmd;
                    item_ch.cmd              <= next_cmd.cmd;
                    item_ch.segment          <= next_cmd.segment;
                    item_ch.lowest_bin       <= next_cmd.lowest_bin;
                    item_ch.bin_count        <= next_cmd.bin_count;
                    item_ch.distance         <= next_cmd.distance;
                    item_ch.address          <= next_cmd.address;
                    item_ch.clear_after_read <= next_cmd.clear_after_read;
                    item_ch.valid            <= 1'b1;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        readout_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("unexpected result count=%0h status=%0d",
                                              result_ch.count, result_ch.status));
                else
                begin
                    want = expected_results.pop_front();
                    if (result_ch.count !== want.count)
                        report_mismatch($sformatf("count %0h, want %0h",
                                                  result_ch.count, want.count));
                    if (result_ch.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  result_ch.status, want.status));
                end
            end
            result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    function automatic command_t make_cmd(input logic [CMD_W-1:0] op, input int seg,
                                          input int lowest, input int cnt, input int dist_q,
                                          input int addr, input bit clr);
        command_t c;
        c.cmd              = op;
        c.segment          = seg[SEGMENT_W-1:0];
        c.lowest_bin       = lowest[LOWEST_W-1:0];
        c.bin_count        = cnt[COUNT_W-1:0];
        c.distance         = dist_q;
        c.address          = addr[ADDR_W-1:0];
        c.clear_after_read = clr;
        return c;
    endfunction

    // Track the layout of appends that will succeed, so samples can aim at real bins
    task automatic queue_command(input command_t c);
        if (c.cmd == CMD_APPEND && plan_loaded < SEGMENTS &&
            plan_allotted + int'(c.bin_count) <= BINS)
        begin
            plan_lowest[plan_loaded] = c.lowest_bin;
            plan_count[plan_loaded]  = int'(c.bin_count);
            plan_loaded++;
            plan_allotted += int'(c.bin_count);
        end
        pending_commands.push_back(c);
    endtask

    task automatic queue_random(input int n);
        command_t c;
        int       pick;
        int       s;
        int       rel;
        longint   target;
        longint   d;
        for (int k = 0; k < n; k++)
        begin
            c.cmd              = CMD_W'($urandom);
            c.segment          = SEGMENT_W'($urandom);
            c.lowest_bin       = LOWEST_W'($urandom);
            c.bin_count        = COUNT_W'($urandom);
            c.distance         = $urandom;
            c.address          = ADDR_W'($urandom);
            c.clear_after_read = 1'($urandom);
            pick = $urandom_range(99);
            if (pick < ((plan_loaded < SEGMENTS) ? 20 : 4))
            begin
                c.cmd = CMD_APPEND;
                if ($urandom_range(9) != 0)
                    c.lowest_bin = LOWEST_W'(int'($urandom_range(4000)) - 2000);
                if ($urandom_range(29) == 0)
                    c.bin_count = '0;
                else if (plan_loaded >= 40 && $urandom_range(4) == 0)
                    c.bin_count = COUNT_W'($urandom_range(512, 8191));
                else
                    c.bin_count = COUNT_W'($urandom_range(1, 48));
            end
            else if (pick < 75)
            begin
                c.cmd = CMD_SAMPLE;
                if (plan_loaded > 0 && $urandom_range(9) != 0)
                begin
                    s = $urandom_range(plan_loaded - 1);
                    c.segment = s[SEGMENT_W-1:0];
                    if (plan_count[s] > 0 && $urandom_range(9) != 0)
                        rel = $urandom_range(plan_count[s] - 1);
                    else
                        rel = int'($urandom_range(plan_count[s] + 3)) - 2;
                    target = plan_lowest[s] + rel;
                    // Invert the bin mapping; leave the random distance if it won't fit
                    if (plan_recip != '0)
                    begin
                        d = (target <<< 32) / longint'({32'b0, plan_recip});
                        if (d >= -64'sd2147483648 && d <= 64'sd2147483647)
                            c.distance = d[31:0];
                    end
                end
            end
            else if (pick < 95)
            begin
                c.cmd = CMD_READ;
                if (plan_allotted > 0 && $urandom_range(3) != 0)
                    c.address = ADDR_W'($urandom_range(plan_allotted - 1));
            end
            else
                c.cmd = CMD_UNUSED;
            queue_command(c);
        end
    endtask

    task automatic write_recip(input logic [RECIP_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        recip_now  = v;
        plan_recip = v;
        @(negedge clk);
    endtask

    // Drain everything, then let the pipeline settle
    task automatic wait_quiet();
        while (pending_commands.size() != 0 || item_ch.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        rst_n                    = 1'b0;
        cfg_wr_en                = 1'b0;
        cfg_wr_data              = '0;
        item_ch.valid            = 1'b0;
        item_ch.cmd              = '0;
        item_ch.segment          = '0;
        item_ch.lowest_bin       = '0;
        item_ch.bin_count        = '0;
        item_ch.distance         = '0;
        item_ch.address          = '0;
        item_ch.clear_after_read = 1'b0;
        result_ch.ready          = 1'b0;
        foreach (counters[i])
            counters[i] = '0;
        segs_loaded       = 0;
        bins_used         = 0;
        plan_loaded       = 0;
        plan_allotted     = 0;
        recip_now         = RECIP_RESET;
        plan_recip        = RECIP_RESET;
        sender_idle_pct   = 16;
        receiver_idle_pct = 82;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // Wait out the counter clearing pass
        @(negedge clk);
        while (!item_ch.ready)
            @(negedge clk);
        write_recip(RECIP_RESET);

        queue_command(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 1'b0));
        queue_command(make_cmd(CMD_UNUSED, 63, -1, 8191, -1, 4095, 1'b1));
        queue_command(make_cmd(CMD_SAMPLE, 0, 0, 0, 0, 0, 1'b0));
        queue_command(make_cmd(CMD_APPEND, 0, -8388608, 1, 0, 0, 1'b0));
        queue_command(make_cmd(CMD_APPEND, 0, 8388607, 1, 0, 0, 1'b0));
        queue_command(make_cmd(CMD_APPEND, 0, 0, 0, 0, 0, 1'b0));
        queue_command(make_cmd(CMD_APPEND, 0, -4, 8, 0, 0, 1'b0));
        queue_command(make_cmd(CMD_APPEND, 0, 100, 4096, 0, 0, 1'b0));
        queue_command(make_cmd(CMD_SAMPLE, 2, 0, 0, 0, 0, 1'b0));
        queue_command(make_cmd(CMD_SAMPLE, 3, 0, 0, -262144, 0, 1'b0));
        queue_command(make_cmd(CMD_SAMPLE, 3, 0, 0, 196608, 0, 1'b0));
        queue_command(make_cmd(CMD_SAMPLE, 3, 0, 0, 262144, 0, 1'b0));
        queue_command(make_cmd(CMD_SAMPLE, 3, 0, 0, -327680, 0, 1'b0));
        queue_command(make_cmd(CMD_SAMPLE, 3, 0, 0, 32'sh7FFF_FFFF, 0, 1'b0));
        queue_command(make_cmd(CMD_SAMPLE, 3, 0, 0, 32'sh8000_0000, 0, 1'b0));
        queue_command(make_cmd(CMD_SAMPLE, 0, 0, 0, 32'sh8000_0000, 0, 1'b0));
        queue_command(make_cmd(CMD_SAMPLE, 1, 0, 0, 32'sh7FFF_FFFF, 0, 1'b0));
        // Exact halves round up: -3.5 lands on -3, 2.5 on 3
        queue_command(make_cmd(CMD_SAMPLE, 3, 0, 0, -229376, 0, 1'b0));
        queue_command(make_cmd(CMD_SAMPLE, 3, 0, 0, 163840, 0, 1'b0));
        queue_command(make_cmd(CMD_SAMPLE, 63, 0, 0, 0, 0, 1'b0));
        queue_command(make_cmd(CMD_READ, 0, 0, 0, 0, 2, 1'b1));
        queue_command(make_cmd(CMD_READ, 0, 0, 0, 0, 2, 1'b0));
        queue_command(make_cmd(CMD_READ, 0, 0, 0, 0, 9, 1'b1));
        queue_command(make_cmd(CMD_READ, 0, 0, 0, 0, 3, 1'b0));
        queue_command(make_cmd(CMD_READ, 0, 0, 0, 0, 4095, 1'b0));
        queue_random(230);
        wait_quiet();

        sender_idle_pct   = 82;
        receiver_idle_pct = 16;
        write_recip(32'hFFFF_FFFF);
        queue_random(120);
        wait_quiet();
        write_recip(32'd1);
        queue_random(110);
        wait_quiet();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_recip($urandom_range(16384, 262144));
        queue_random(120);
        wait_quiet();
        // Zero reciprocal sends every distance to bin zero
        write_recip('0);
        queue_random(40);
        wait_quiet();
        write_recip(RECIP_RESET);
        queue_random(60);
        wait_quiet();

        if (error_count == 0)
            $display("segmented_histogram_accumulator_top regression: pass");
        else
            $display("segmented_histogram_accumulator_top regression: fail");
        $finish;
    end

endmodule

/* files.f */
sv/shist_pkg.sv
sv/shist_ifs.sv
sv/shist_ctr_bank.sv
sv/segmented_histogram_accumulator_top.sv
sv/shist_checker.sv
dv/testbench.sv
